// ----- design/assert_macros.svh -----
// Assertion macros used by the console writer sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TCW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TCW_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- design/tcw_pkg.sv -----
// Types and constants of the text console writer.
package tcw_pkg;

   // Field widths of the request and response
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned INDEX_W = 11;
   localparam int unsigned TDATA_W = 32;

   // Special bytes
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] NIBBLE_MASK    = 8'h0F;

   typedef enum logic [1:0] {
      MODE_PUT   = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_FILL  = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_MOVE,
      ST_MOVE_END,
      ST_BOTTOM,
      ST_CLEAR,
      ST_FILL,
      ST_FILL_END,
      ST_DONE
   } state_type;

   // One screen cell: attribute in the high byte, glyph in the low byte
   typedef struct packed {
      logic [BYTE_W-1:0] attr;
      logic [BYTE_W-1:0] glyph;
   } cell_type;

   typedef struct packed {
      mode_type           mode;
      logic [BYTE_W-1:0]  character;
      logic [BYTE_W-1:0]  color;
      logic [INDEX_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] cursor_cell;
      logic [BYTE_W-1:0]  cell_char;
      logic [BYTE_W-1:0]  cell_attr;
   } rsp_type;

endpackage

// ----- design/text_console_writer.sv -----
// Top level of the text console writer: stream ports, sequencer and screen store.
//
//   channel | direction | ports                  | contents
//   --------+-----------+------------------------+-----------------------------------
//   req     | in        | req_tvalid/tready/data | mode in tuser, char/color/index
//   rsp     | out       | rsp_tvalid/tready/data | cursor cell, read char and attr
//
// Put character goes from idle straight to done; read passes a read state for the
// registered store read. Clear and fill sweep all cells, one store write per cycle.
// A scroll adds a read/write pass over the rows and a bottom fill.
// After reset a clearing pass zeroes all CELLS cells (2000 at 80x25),
// with req_tready low. A request is taken while a response still waits;
// a finished request then holds until the response register frees.
module text_console_writer #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [7:0] character, [15:8] color, [26:16] cell_index, rest zero
   input  logic [tcw_pkg::TDATA_W-1:0]  req_tdata,
   // [1:0] mode
   input  logic [tcw_pkg::MODE_W-1:0]   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [10:0] cursor_cell, [18:11] cell_char, [26:19] cell_attr, rest zero
   output logic [tcw_pkg::TDATA_W-1:0]  rsp_tdata
);
   import tcw_pkg::*;

   localparam int unsigned CELLS  = COLUMNS * ROWS;
   localparam int unsigned ADDR_W = $clog2(CELLS);
   localparam int unsigned PAD_W  = TDATA_W - INDEX_W - 2 * BYTE_W;

   req_type             req;
   rsp_type             rsp;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   cell_type            wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   cell_type            rd_data;

   // Unpack the request
   assign req.mode       = mode_type'(req_tuser);
   assign req.character  = req_tdata[BYTE_W-1:0];
   assign req.color      = req_tdata[2*BYTE_W-1:BYTE_W];
   assign req.cell_index = req_tdata[2*BYTE_W+INDEX_W-1:2*BYTE_W];

   // Pack the response
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp.cell_attr, rsp.cell_char, rsp.cursor_cell};

   tcw_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .ADDR_W  (ADDR_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   tcw_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ----- design/tcw_ram.sv -----
// Screen store: one write port, one registered read port.
module tcw_ram #(
   parameter int unsigned DEPTH  = 2000,
   parameter int unsigned ADDR_W = 11
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  tcw_pkg::cell_type    wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output tcw_pkg::cell_type    rd_data
);
   import tcw_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   // Write the addressed cell
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/tcw_seq.sv -----
// Command sequencer: cursor, store sweeps and the response register.
`include "assert_macros.svh"

module tcw_seq #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25,
   parameter int unsigned ADDR_W  = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tcw_pkg::req_type     req,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tcw_pkg::rsp_type     rsp,
   output logic                 wr_en,
   output logic [ADDR_W-1:0]    wr_addr,
   output tcw_pkg::cell_type    wr_data,
   output logic                 rd_en,
   output logic [ADDR_W-1:0]    rd_addr,
   input  tcw_pkg::cell_type    rd_data
);
   import tcw_pkg::*;

   localparam int unsigned CELLS  = COLUMNS * ROWS;
   localparam int unsigned BOTTOM = CELLS - COLUMNS;
   localparam int unsigned CNT_W  = $clog2(CELLS + 1);
   localparam int unsigned COL_W  = $clog2(COLUMNS);

   localparam logic [CNT_W-1:0] CNT_CELLS   = CNT_W'(CELLS);
   localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(CELLS - 1);
   localparam logic [CNT_W-1:0] CNT_BOTTOM  = CNT_W'(BOTTOM);
   localparam logic [CNT_W-1:0] CNT_MOVE_LT = CNT_W'(BOTTOM - 1);
   localparam logic [CNT_W-1:0] CNT_COLUMNS = CNT_W'(COLUMNS);
   localparam logic [COL_W-1:0] COL_LAST    = COL_W'(COLUMNS - 1);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    cursor_ff, cursor_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [BYTE_W-1:0]   color_ff, color_in;
   logic [BYTE_W-1:0]   fill_attr_ff, fill_attr_in;
   logic                pend_ff, pend_in;
   logic [CNT_W-1:0]    pend_addr_ff, pend_addr_in;
   logic                rd_ok_ff, rd_ok_in;
   cell_type            res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_fire;
   logic                slot_free;
   logic                cnt_last;
   logic                is_newline;
   logic                is_backspace;
   logic [CNT_W-1:0]    nl_cursor;
   logic [CNT_W-1:0]    adv_cursor;
   logic                put_scroll;
   logic                idx_ok;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign cnt_last   = (cnt_ff == CNT_LAST);

   // Decode the put-char cases
   assign is_newline   = (req.character == CHAR_NEWLINE);
   assign is_backspace = (req.character == CHAR_BACKSPACE);
   assign nl_cursor    = cursor_ff + CNT_COLUMNS - CNT_W'(col_ff);
   assign adv_cursor   = cursor_ff + CNT_W'(1);
   assign put_scroll   = is_newline ? (nl_cursor == CNT_CELLS)
                       : (!is_backspace && (adv_cursor == CNT_CELLS));
   assign idx_ok       = (32'(req.cell_index) < 32'(CELLS));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req.mode)
                  MODE_PUT:   state_in = put_scroll ? ST_MOVE : ST_DONE;
                  MODE_CLEAR: state_in = ST_CLEAR;
                  MODE_FILL:  state_in = ST_FILL;
                  MODE_READ:  state_in = ST_READ;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_READ:     state_in = ST_DONE;
         ST_MOVE: begin
            if (cnt_ff == CNT_MOVE_LT) state_in = ST_MOVE_END;
         end
         ST_MOVE_END: state_in = ST_BOTTOM;
         ST_BOTTOM: begin
            if (cnt_last) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (cnt_last) state_in = ST_DONE;
         end
         ST_FILL: begin
            if (cnt_last) state_in = ST_FILL_END;
         end
         ST_FILL_END: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_INIT;
      endcase
   end

   // Datapath, store accesses and response
   always_comb begin
      cnt_in       = cnt_ff;
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      color_in     = color_ff;
      fill_attr_in = fill_attr_ff;
      pend_in      = 1'b0;
      pend_addr_in = cnt_ff;
      rd_ok_in     = rd_ok_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(cnt_ff);
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(cnt_ff);

      unique case (state_ff)
         ST_INIT: begin
            // Zero one cell per cycle after reset
            wr_en  = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in   = '0;
               color_in = req.color;
               res_in   = '0;
               unique case (req.mode)
                  MODE_PUT: begin
                     if (is_newline) begin
                        cursor_in = put_scroll ? CNT_BOTTOM : nl_cursor;
                        col_in    = '0;
                     end else if (is_backspace) begin
                        if (cursor_ff != '0) begin
                           cursor_in    = cursor_ff - CNT_W'(1);
                           col_in       = (col_ff == '0) ? COL_LAST
                                                         : col_ff - COL_W'(1);
                           wr_en        = 1'b1;
                           wr_addr      = ADDR_W'(cursor_ff - CNT_W'(1));
                           wr_data.attr  = req.color;
                           wr_data.glyph = CHAR_SPACE;
                        end
                     end else begin
                        cursor_in     = put_scroll ? CNT_BOTTOM : adv_cursor;
                        col_in        = (col_ff == COL_LAST) ? '0 : col_ff + COL_W'(1);
                        wr_en         = 1'b1;
                        wr_addr       = ADDR_W'(cursor_ff);
                        wr_data.attr  = req.color;
                        wr_data.glyph = req.character;
                     end
                  end
                  MODE_CLEAR: begin
                     cursor_in = '0;
                     col_in    = '0;
                  end
                  MODE_FILL: begin
                  end
                  MODE_READ: begin
                     rd_ok_in = idx_ok;
                     rd_en    = 1'b1;
                     rd_addr  = idx_ok ? ADDR_W'(req.cell_index) : '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            res_in = rd_ok_ff ? rd_data : '0;
         end
         ST_MOVE: begin
            // Read row below, write it one row up in the next cycle
            rd_en        = 1'b1;
            rd_addr      = ADDR_W'(cnt_ff + CNT_COLUMNS);
            pend_in      = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            wr_en        = pend_ff;
            wr_addr      = ADDR_W'(pend_addr_ff);
            wr_data      = rd_data;
         end
         ST_MOVE_END: begin
            // Last moved cell is the row-above attribute source
            wr_en        = 1'b1;
            wr_addr      = ADDR_W'(pend_addr_ff);
            wr_data      = rd_data;
            fill_attr_in = rd_data.attr;
            cnt_in       = CNT_BOTTOM;
         end
         ST_BOTTOM: begin
            wr_en         = 1'b1;
            wr_data.attr  = fill_attr_ff;
            wr_data.glyph = CHAR_SPACE;
            cnt_in        = cnt_ff + CNT_W'(1);
         end
         ST_CLEAR: begin
            wr_en         = 1'b1;
            wr_data.attr  = color_ff;
            wr_data.glyph = CHAR_SPACE;
            cnt_in        = cnt_ff + CNT_W'(1);
         end
         ST_FILL, ST_FILL_END: begin
            // Replace the background nibble of the cell read last cycle
            if (state_ff == ST_FILL) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            wr_en         = pend_ff;
            wr_addr       = ADDR_W'(pend_addr_ff);
            wr_data.attr  = ((color_ff & NIBBLE_MASK) << 4) | (rd_data.attr & NIBBLE_MASK);
            wr_data.glyph = rd_data.glyph;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.cursor_cell = INDEX_W'(cursor_ff);
               rsp_in.cell_char   = res_ff.glyph;
               rsp_in.cell_attr   = res_ff.attr;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         cursor_ff    <= '0;
         col_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      color_ff     <= color_in;
      fill_attr_ff <= fill_attr_in;
      pend_addr_ff <= pend_addr_in;
      rd_ok_ff     <= rd_ok_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `TCW_NEVER(a_cursor_range, clock, reset, cursor_ff >= CNT_CELLS, "cursor beyond last cell")
   `TCW_NEVER(a_no_rw_clash, clock, reset, wr_en && rd_en && (wr_addr == rd_addr), "read and write hit one cell")
   `TCW_ASSERT(a_done_loads, clock, reset, (state_ff == ST_DONE && slot_free) |=> rsp_valid_ff, "finished request not presented")
   `TCW_ASSERT(a_col_wraps, clock, reset, (state_ff == ST_MOVE) |-> (cursor_ff == CNT_BOTTOM && col_ff == '0), "scroll left cursor off bottom row start")

endmodule
